@@ hw/rtl/clt_pkg.sv @@
// ----------------------------------------------------------------------------
// clt_pkg
// shared types, byte codes and result kinds of the command line tokenizer
// ----------------------------------------------------------------------------
package clt_pkg;

	localparam int TOKEN_LIMIT_DEF = 16;
	localparam int WORD_BYTES_DEF  = 64;
	localparam int EV_MAX          = 3;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_PIPE  = 8'h7c;

	typedef enum logic [3:0] {
		KIND_BYTE    = 4'd0,
		KIND_WEND    = 4'd1,
		KIND_PIPE    = 4'd2,
		KIND_IN      = 4'd3,
		KIND_OUT     = 4'd4,
		KIND_APPEND  = 4'd5,
		KIND_END     = 4'd6,
		KIND_UNTERM  = 4'd7,
		KIND_TRUNC   = 4'd8
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_out;
		logic [4:0]  token_index;
		logic [5:0]  word_length;
		logic [4:0]  token_total;
	} ev_t;

	typedef struct packed {
		logic [1:0]            cnt;
		ev_t [EV_MAX-1:0]      ev;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t head;
	} head_t;

	function automatic ev_t mk_ev(kind_t k, logic [7:0] b, logic [31:0] idx,
			logic [31:0] len, logic [31:0] tot);
		ev_t e;
		e.kind        = k;
		e.byte_out    = b;
		e.token_index = idx[4:0];
		e.word_length = len[5:0];
		e.token_total = tot[4:0];
		return e;
	endfunction

endpackage

@@ hw/rtl/clt_front.sv @@
// ----------------------------------------------------------------------------
// clt_front
// per-byte lexer state; turns each byte into a bundle of up to three events
// ----------------------------------------------------------------------------
module clt_front #(
	parameter int TOKEN_LIMIT = clt_pkg::TOKEN_LIMIT_DEF,
	parameter int WORD_BYTES  = clt_pkg::WORD_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      char_in,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            queue_full,
	output logic            push,
	output clt_pkg::bundle_t push_data
);
	import clt_pkg::*;

	localparam int TW = $clog2(TOKEN_LIMIT + 1);
	localparam int LW = $clog2(WORD_BYTES);

	logic          quote_q, word_q, pend_q, stop_q;
	logic [LW-1:0] len_q;
	logic [TW-1:0] tok_q;

	logic          q, w, pg, st, done, lend;
	logic [LW-1:0] len;
	logic [TW-1:0] t;
	logic [1:0]    n;
	bundle_t       bnd;
	logic          accept;

	assign in_ready  = !queue_full;
	assign accept    = in_valid && in_ready;
	assign push      = accept && (n != 2'd0);
	assign push_data = bnd;

	always_comb begin
		q    = quote_q;
		w    = word_q;
		len  = len_q;
		t    = tok_q;
		pg   = pend_q;
		st   = stop_q;
		n    = 2'd0;
		done = 1'b0;
		bnd  = '0;
		lend = (char_in == CH_NUL) || (char_in == CH_LF);
		if (st) begin
			if (lend) begin
				st = 1'b0;
			end
		end else begin
			if (pg) begin
				pg = 1'b0;
				if (char_in == CH_GT) begin
					bnd.ev[n] = mk_ev(KIND_APPEND, 8'd0, 32'(t), 32'd0, 32'd0);
					n = n + 2'd1;
					t = t + TW'(1);
					done = 1'b1;
				end else begin
					bnd.ev[n] = mk_ev(KIND_OUT, 8'd0, 32'(t), 32'd0, 32'd0);
					n = n + 2'd1;
					t = t + TW'(1);
				end
			end
			if (!done) begin
				if (lend) begin
					if (q) begin
						bnd.ev[n] = mk_ev(KIND_UNTERM, 8'd0, 32'(t), 32'd0, 32'd0);
						n = n + 2'd1;
					end else begin
						if (w) begin
							bnd.ev[n] = mk_ev(KIND_WEND, 8'd0, 32'(t), 32'(len), 32'd0);
							n = n + 2'd1;
							t = t + TW'(1);
						end
						bnd.ev[n] = mk_ev(KIND_END, 8'd0, 32'(t), 32'd0, 32'(t));
						n = n + 2'd1;
					end
					q   = 1'b0;
					w   = 1'b0;
					len = '0;
					t   = '0;
					pg  = 1'b0;
					st  = 1'b0;
				end else if (q) begin
					if (char_in == CH_QUOTE) begin
						bnd.ev[n] = mk_ev(KIND_WEND, 8'd0, 32'(t), 32'(len), 32'd0);
						n = n + 2'd1;
						t = t + TW'(1);
						w = 1'b0;
						q = 1'b0;
						len = '0;
					end else if (len < LW'(WORD_BYTES - 1)) begin
						bnd.ev[n] = mk_ev(KIND_BYTE, char_in, 32'(t), 32'd0, 32'd0);
						n = n + 2'd1;
						len = len + LW'(1);
					end
				end else if (char_in == CH_QUOTE) begin
					if (!w && (t >= TW'(TOKEN_LIMIT))) begin
						bnd.ev[n] = mk_ev(KIND_TRUNC, 8'd0, 32'(t), 32'd0, 32'(t));
						n = n + 2'd1;
						w = 1'b0;
						len = '0;
						t = '0;
						st = 1'b1;
					end else begin
						q = 1'b1;
						w = 1'b1;
					end
				end else if ((char_in == CH_PIPE) || (char_in == CH_LT) ||
						(char_in == CH_GT)) begin
					if (w) begin
						bnd.ev[n] = mk_ev(KIND_WEND, 8'd0, 32'(t), 32'(len), 32'd0);
						n = n + 2'd1;
						t = t + TW'(1);
						w = 1'b0;
						len = '0;
					end
					if (t >= TW'(TOKEN_LIMIT)) begin
						bnd.ev[n] = mk_ev(KIND_TRUNC, 8'd0, 32'(t), 32'd0, 32'(t));
						n = n + 2'd1;
						t = '0;
						st = 1'b1;
					end else if (char_in == CH_GT) begin
						pg = 1'b1;
					end else begin
						bnd.ev[n] = mk_ev((char_in == CH_PIPE) ? KIND_PIPE : KIND_IN,
							8'd0, 32'(t), 32'd0, 32'd0);
						n = n + 2'd1;
						t = t + TW'(1);
					end
				end else if ((char_in == CH_SPACE) || (char_in == CH_TAB)) begin
					if (w) begin
						bnd.ev[n] = mk_ev(KIND_WEND, 8'd0, 32'(t), 32'(len), 32'd0);
						n = n + 2'd1;
						t = t + TW'(1);
						w = 1'b0;
						len = '0;
					end
				end else begin
					if (!w && (t >= TW'(TOKEN_LIMIT))) begin
						bnd.ev[n] = mk_ev(KIND_TRUNC, 8'd0, 32'(t), 32'd0, 32'(t));
						n = n + 2'd1;
						len = '0;
						t = '0;
						st = 1'b1;
					end else begin
						if (!w) begin
							w = 1'b1;
							len = '0;
						end
						if (len < LW'(WORD_BYTES - 1)) begin
							bnd.ev[n] = mk_ev(KIND_BYTE, char_in, 32'(t), 32'd0, 32'd0);
							n = n + 2'd1;
							len = len + LW'(1);
						end
					end
				end
			end
		end
		bnd.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= 1'b0;
			word_q  <= 1'b0;
			pend_q  <= 1'b0;
			stop_q  <= 1'b0;
			len_q   <= '0;
			tok_q   <= '0;
		end else if (accept) begin
			quote_q <= q;
			word_q  <= w;
			pend_q  <= pg;
			stop_q  <= st;
			len_q   <= len;
			tok_q   <= t;
		end
	end

endmodule

@@ hw/rtl/clt_fifo.sv @@
// ----------------------------------------------------------------------------
// clt_fifo
// short queue of event bundles between the lexer front and the result back
// ----------------------------------------------------------------------------
module clt_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  clt_pkg::bundle_t push_data,
	output logic             full,
	input  logic             pop,
	output clt_pkg::head_t   head
);
	import clt_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	bundle_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(QUEUE_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/clt_back.sv @@
// ----------------------------------------------------------------------------
// clt_back
// walks each queued bundle one event at a time into the output register
// ----------------------------------------------------------------------------
module clt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  clt_pkg::head_t head,
	output logic           pop,
	output logic [3:0]     kind,
	output logic [7:0]     byte_out,
	output logic [4:0]     token_index,
	output logic [5:0]     word_length,
	output logic [4:0]     token_total,
	output logic           last_of_run,
	output logic           out_valid,
	input  logic           out_ready
);
	import clt_pkg::*;

	logic [1:0] slot_q;
	logic       load, last;
	ev_t        cur;
	ev_t        ev_q;
	logic       last_q, valid_q;

	assign cur  = head.head.ev[slot_q];
	assign last = (slot_q == (head.head.cnt - 2'd1));
	assign load = head.valid && (!valid_q || out_ready);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				slot_q  <= last ? 2'd0 : slot_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ev_q   <= cur;
			last_q <= last;
		end
	end

	assign out_valid   = valid_q;
	assign kind        = ev_q.kind;
	assign byte_out    = ev_q.byte_out;
	assign token_index = ev_q.token_index;
	assign word_length = ev_q.word_length;
	assign token_total = ev_q.token_total;
	assign last_of_run = last_q;

endmodule

@@ hw/rtl/command_line_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// command_line_tokenizer_top
// byte-serial command line lexer emitting word bytes, word ends and operators
// ----------------------------------------------------------------------------
// One command byte is taken per cycle whenever the bundle queue has room. The
// front lexes each byte combinationally into zero to three token events;
// the back drains them from an output register at one result transfer per
// cycle while the sink is ready, so a line sustains one byte per cycle while
// most bytes give at most one result; a byte with more holds the back until
// all are sent, each via the bundle queue, then the output register. The
// four entry queue sets how far the front may run ahead of a stalled sink.
module command_line_tokenizer_top #(
	parameter int TOKEN_LIMIT = clt_pkg::TOKEN_LIMIT_DEF,
	parameter int WORD_BYTES  = clt_pkg::WORD_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_in,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [3:0] kind,
	output logic [7:0] byte_out,
	output logic [4:0] token_index,
	output logic [5:0] word_length,
	output logic [4:0] token_total,
	output logic       last_of_run,
	output logic       out_valid,
	input  logic       out_ready
);
	import clt_pkg::*;

	logic    push, full, pop;
	bundle_t push_data;
	head_t   head;

	clt_front #(
		.TOKEN_LIMIT(TOKEN_LIMIT),
		.WORD_BYTES (WORD_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_in),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.queue_full(full),
		.push      (push),
		.push_data (push_data)
	);

	clt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.head     (head)
	);

	clt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.kind       (kind),
		.byte_out   (byte_out),
		.token_index(token_index),
		.word_length(word_length),
		.token_total(token_total),
		.last_of_run(last_of_run),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule
